[hdl/pgrb_pkg.sv]
// Shared constants, types and helpers for the proportional glyph row blitter.
`timescale 1ns / 1ps
package pgrb_pkg;

    localparam int GLYPH_ROWS_DEF  = 10;
    localparam int LINE_PITCH_DEF  = 320;
    localparam int GLYPH_COUNT_DEF = 256;

    // map and advance tables are always indexed by a full byte
    localparam int TABLE_DEPTH = 256;
    localparam int CLIP_MARGIN = 10;

    localparam logic [2:0] CMD_LOAD_MAP   = 3'd0;
    localparam logic [2:0] CMD_LOAD_ADV   = 3'd1;
    localparam logic [2:0] CMD_LOAD_GLYPH = 3'd2;
    localparam logic [2:0] CMD_START      = 3'd3;
    localparam logic [2:0] CMD_CHAR       = 3'd4;

    localparam logic [1:0] REG_BAND_TOP    = 2'd0;
    localparam logic [1:0] REG_BAND_BOTTOM = 2'd1;
    localparam logic [1:0] REG_FRAME_BASE  = 2'd2;

    localparam logic [7:0]  BAND_BOTTOM_RST = 8'd199;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_ADV,
        S_ROW
    } t_state;

    // code modulo count by binary long reduction, eight compare/subtract steps
    function automatic logic [7:0] glyph_wrap(logic [7:0] code, logic [15:0] count);
        logic [15:0] v;
        logic [15:0] m;
        v = {8'd0, code};
        for (int k = 7; k >= 0; k--) begin
            m = count << k;
            if (v >= m) begin
                v = v - m;
            end
        end
        return v[7:0];
    endfunction

endpackage

[hdl/pgrb_in_if.sv]
// Command channel: valid/ready handshake with the command payload.
`timescale 1ns / 1ps
interface pgrb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [11:0] table_index;
    logic [15:0] table_value;
    logic [8:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  ink_color;
    logic [7:0]  char_code;

    modport source (
        output valid, command, table_index, table_value, pos_x, pos_y,
               ink_color, char_code,
        input  ready
    );
    modport sink (
        input  valid, command, table_index, table_value, pos_x, pos_y,
               ink_color, char_code,
        output ready
    );
endinterface

[hdl/pgrb_out_if.sv]
// Row write channel: valid/ready handshake with one glyph row write per beat.
`timescale 1ns / 1ps
interface pgrb_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        write_address;
    logic [15:0]        pixel_mask;
    logic [7:0]         pixel_color;
    logic signed [15:0] draw_width;
    logic               run_last;

    modport source (
        output valid, write_address, pixel_mask, pixel_color, draw_width, run_last,
        input  ready
    );
    modport sink (
        input  valid, write_address, pixel_mask, pixel_color, draw_width, run_last,
        output ready
    );
endinterface

[hdl/pgrb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pgrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/proportional_glyph_row_blitter_unit.sv]
// A character beat issues the map read on acceptance, the advance read in S_MAP and
// the first glyph read in S_ADV; S_ROW then writes one row per glyph memory read,
// holding while the output stalls. Loads, start and string end stay in S_IDLE.
// The output register holds a finished row while the next one is fetched.
// Reset (sync, active low) clears control, pen, width and registers; tables stay unwritten.
`timescale 1ns / 1ps
module proportional_glyph_row_blitter_unit #(
    parameter int GLYPH_ROWS  = pgrb_pkg::GLYPH_ROWS_DEF,
    parameter int LINE_PITCH  = pgrb_pkg::LINE_PITCH_DEF,
    parameter int GLYPH_COUNT = pgrb_pkg::GLYPH_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pgrb_in_if.sink     i_in,
    pgrb_out_if.source  o_out
);
    import pgrb_pkg::*;

    localparam int GLYPH_WORDS = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GADDR_W     = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
    localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam logic [15:0]      PITCH16  = 16'(LINE_PITCH);
    localparam logic [15:0]      COUNT16  = 16'(GLYPH_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

    t_state r_state, n_state;

    logic [7:0]         r_band_top, r_band_bot;
    logic [15:0]        r_frame_base;
    logic [15:0]        r_pen;
    logic [15:0]        r_width;
    logic               r_active;
    logic [7:0]         r_color;
    logic [7:0]         r_glyph;
    logic [15:0]        r_adv;
    logic [GADDR_W-1:0] r_gaddr;
    logic [ROW_W-1:0]   r_row;
    logic [15:0]        r_row_addr;

    logic               r_out_valid;
    logic [15:0]        r_out_addr, r_out_mask;
    logic [7:0]         r_out_color;
    logic [15:0]        r_out_width;
    logic               r_out_last;

    logic               in_acc;
    logic               map_we, adv_we, glyph_we;
    logic               map_re, adv_re, glyph_re;
    logic [7:0]         adv_raddr;
    logic [GADDR_W-1:0] glyph_raddr, glyph_base;
    logic [7:0]         map_rdata, adv_rdata;
    logic [15:0]        glyph_rdata;
    logic [7:0]         wrapped;
    logic [15:0]        adv_ext;
    logic               can_load, row_load, row_last;
    logic [15:0]        start_pen;
    logic               drop;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign wrapped    = glyph_wrap(map_rdata, COUNT16);
    assign adv_ext    = {{8{adv_rdata[7]}}, adv_rdata};
    assign glyph_base = GADDR_W'(int'(r_glyph) * GLYPH_ROWS);
    assign can_load   = !r_out_valid || o_out.ready;
    assign row_load   = (r_state == S_ROW) && can_load;
    assign row_last   = (r_row == LAST_ROW);

    assign start_pen = r_frame_base + 16'(32'(i_in.pos_y) * 32'(LINE_PITCH))
                     + 16'(i_in.pos_x);
    // top clip: y <= top - 10 taken as y + 10 <= top without sign handling
    assign drop = (i_in.pos_y > r_band_bot)
               || ((9'(i_in.pos_y) + 9'(CLIP_MARGIN)) <= {1'b0, r_band_top});

    // table write enables and read requests
    always_comb begin
        map_we      = 1'b0;
        adv_we      = 1'b0;
        glyph_we    = 1'b0;
        map_re      = 1'b0;
        adv_re      = 1'b0;
        glyph_re    = 1'b0;
        adv_raddr   = wrapped;
        glyph_raddr = glyph_base;
        if (in_acc) begin
            unique case (i_in.command)
                CMD_LOAD_MAP:   map_we   = (i_in.table_index < 12'(TABLE_DEPTH));
                CMD_LOAD_ADV:   adv_we   = (i_in.table_index < 12'(TABLE_DEPTH));
                CMD_LOAD_GLYPH: glyph_we = (int'(i_in.table_index) < GLYPH_WORDS);
                CMD_CHAR:       map_re   = r_active && (i_in.char_code != 8'd0);
                default: ;
            endcase
        end
        unique case (r_state)
            S_MAP: adv_re = 1'b1;
            S_ADV: glyph_re = 1'b1;
            S_ROW: begin
                glyph_re    = row_load && !row_last;
                glyph_raddr = r_gaddr;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (map_re) n_state = S_MAP;
            S_MAP:  n_state = S_ADV;
            S_ADV:  n_state = S_ROW;
            S_ROW:  if (row_load && row_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    pgrb_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (i_in.table_index[7:0]),
        .i_wdata (i_in.table_value[7:0]),
        .i_re    (map_re),
        .i_raddr (i_in.char_code),
        .o_rdata (map_rdata)
    );

    pgrb_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_adv (
        .i_clk   (i_clk),
        .i_we    (adv_we),
        .i_waddr (i_in.table_index[7:0]),
        .i_wdata (i_in.table_value[7:0]),
        .i_re    (adv_re),
        .i_raddr (adv_raddr),
        .o_rdata (adv_rdata)
    );

    pgrb_ram #(.WIDTH(16), .DEPTH(GLYPH_WORDS)) u_glyph (
        .i_clk   (i_clk),
        .i_we    (glyph_we),
        .i_waddr (GADDR_W'(i_in.table_index)),
        .i_wdata (i_in.table_value),
        .i_re    (glyph_re),
        .i_raddr (glyph_raddr),
        .o_rdata (glyph_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_band_top   <= 8'd0;
            r_band_bot   <= BAND_BOTTOM_RST;
            r_frame_base <= 16'd0;
            r_pen        <= 16'd0;
            r_width      <= 16'd0;
            r_active     <= 1'b0;
            r_color      <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_BAND_TOP:    r_band_top   <= i_cfg_data[7:0];
                    REG_BAND_BOTTOM: r_band_bot   <= i_cfg_data[7:0];
                    REG_FRAME_BASE:  r_frame_base <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc && i_in.command == CMD_START) begin
                r_width <= 16'd0;
                if (drop) begin
                    r_active <= 1'b0;
                end else begin
                    r_active <= 1'b1;
                    r_color  <= i_in.ink_color;
                    r_pen    <= start_pen;
                end
            end
            if (in_acc && i_in.command == CMD_CHAR && i_in.char_code == 8'd0) begin
                r_active <= 1'b0;
            end

            if (r_state == S_ADV) begin
                r_width <= r_width + adv_ext;
            end
            if (row_load && row_last) begin
                r_pen <= r_pen + r_adv;
            end

            if (row_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-character datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP) begin
            r_glyph <= wrapped;
        end
        if (r_state == S_ADV) begin
            r_adv      <= adv_ext;
            r_gaddr    <= glyph_base + GADDR_W'(1);
            r_row      <= '0;
            r_row_addr <= r_pen;
        end
        if (row_load) begin
            r_out_addr  <= r_row_addr;
            r_out_mask  <= glyph_rdata;
            r_out_color <= r_color;
            r_out_width <= r_width;
            r_out_last  <= row_last;
            r_row_addr  <= r_row_addr + PITCH16;
            r_row       <= r_row + ROW_W'(1);
            r_gaddr     <= r_gaddr + GADDR_W'(1);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.write_address = r_out_addr;
    assign o_out.pixel_mask    = r_out_mask;
    assign o_out.pixel_color   = r_out_color;
    assign o_out.draw_width    = r_out_width;
    assign o_out.run_last      = r_out_last;
endmodule
